### rtl/lcd_segment_frame_decoder_macros.svh
// Assertion macros for the LCD segment frame decoder
`ifndef LCD_SEGMENT_FRAME_DECODER_MACROS_SVH
`define LCD_SEGMENT_FRAME_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LSFD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`define LSFD_ASSERT_LATER2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);
`else
`define LSFD_ASSERT_SAME(lbl, ante, cons, msg)
`define LSFD_ASSERT_NEXT(lbl, ante, cons, msg)
`define LSFD_ASSERT_LATER2(lbl, ante, cons, msg)
`endif

`endif

### rtl/lsfd_pkg.sv
// Shared types, constants and segment decoder for the LCD segment frame decoder
package lsfd_pkg;

  localparam int unsigned FRAME_LEN      = 20;
  localparam int unsigned KEEP_LEN       = 15;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [4:0] POS_IDLE = 5'(FRAME_LEN);
  localparam logic [4:0] POS_LAST = 5'(FRAME_LEN - 1);
  localparam logic [4:0] POS_KEEP = 5'(KEEP_LEN);

  localparam logic [6:0] SEG_0     = 7'b1011111;
  localparam logic [6:0] SEG_1     = 7'b1010000;
  localparam logic [6:0] SEG_2     = 7'b1101101;
  localparam logic [6:0] SEG_3     = 7'b1111100;
  localparam logic [6:0] SEG_4     = 7'b1110010;
  localparam logic [6:0] SEG_5     = 7'b0111110;
  localparam logic [6:0] SEG_6     = 7'b0111111;
  localparam logic [6:0] SEG_7     = 7'b1010100;
  localparam logic [6:0] SEG_8     = 7'b1111111;
  localparam logic [6:0] SEG_9     = 7'b1111110;
  localparam logic [6:0] SEG_D     = 7'b1111001;
  localparam logic [6:0] SEG_I     = 7'b0010000;
  localparam logic [6:0] SEG_O     = 7'b0111001;
  localparam logic [6:0] SEG_L     = 7'b0001011;
  localparam logic [6:0] SEG_BLANK = 7'b0000000;

  localparam logic [3:0] CODE_D       = 4'd10;
  localparam logic [3:0] CODE_I       = 4'd11;
  localparam logic [3:0] CODE_O       = 4'd12;
  localparam logic [3:0] CODE_L       = 4'd13;
  localparam logic [3:0] CODE_BLANK   = 4'd14;
  localparam logic [3:0] CODE_UNKNOWN = 4'd15;

  typedef logic [KEEP_LEN-1:0][7:0] frame_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } frame_xfer_t;

  typedef struct packed {
    logic       done;
    logic [4:0] pos;
  } front_status_t;

  function automatic logic [3:0] seg_decode(input logic [6:0] pat);
    logic [3:0] code;
    unique case (pat)
      SEG_0:     code = 4'd0;
      SEG_1:     code = 4'd1;
      SEG_2:     code = 4'd2;
      SEG_3:     code = 4'd3;
      SEG_4:     code = 4'd4;
      SEG_5:     code = 4'd5;
      SEG_6:     code = 4'd6;
      SEG_7:     code = 4'd7;
      SEG_8:     code = 4'd8;
      SEG_9:     code = 4'd9;
      SEG_D:     code = CODE_D;
      SEG_I:     code = CODE_I;
      SEG_O:     code = CODE_O;
      SEG_L:     code = CODE_L;
      SEG_BLANK: code = CODE_BLANK;
      default:   code = CODE_UNKNOWN;
    endcase
    return code;
  endfunction

endpackage

### rtl/lsfd_front.sv
// Front end: byte counting, frame store and frame hand-off
module lsfd_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [7:0]             rx_byte,
  input  logic                   frame_start,
  output lsfd_pkg::frame_xfer_t  push,
  output lsfd_pkg::front_status_t status
);
  import lsfd_pkg::*;

  logic [4:0] pos_r, pos_nxt;
  logic [4:0] pos_eff;
  logic [4:0] pos_inc;
  logic       live;
  logic       wr_en;
  logic       done;
  frame_t     store_r;

  assign pos_eff = frame_start ? 5'd0 : pos_r;
  assign live    = accept && (frame_start || (pos_r < POS_IDLE));
  assign pos_inc = pos_eff + 5'd1;
  assign wr_en   = live && (pos_eff < POS_KEEP);
  assign done    = live && (pos_eff == POS_LAST);

  always_comb begin
    pos_nxt = pos_r;
    if (live) begin
      pos_nxt = pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_IDLE;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < KEEP_LEN; i++) begin
      if (wr_en && (pos_eff[3:0] == 4'(i))) begin
        store_r[i] <= rx_byte;
      end
    end
  end

  // bytes 15 to 19 are not kept, so the store is complete when the last byte lands
  assign push.valid  = done;
  assign push.frame  = store_r;
  assign status.done = done;
  assign status.pos  = pos_r;

endmodule

### rtl/lsfd_queue.sv
// Frame queue between front end and decode stage
module lsfd_queue #(
  parameter int unsigned DEPTH = lsfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lsfd_pkg::frame_xfer_t push,
  input  logic                  pop,
  output lsfd_pkg::frame_xfer_t head,
  output logic                  full
);
  import lsfd_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  frame_t        mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          wr;
  logic          rd;

  assign full = (count_r == CW'(DEPTH));
  assign wr   = push.valid && !full;
  assign rd   = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.frame = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr && !rd) begin
      count_nxt = count_r + 1'b1;
    end else if (rd && !wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= push.frame;
    end
  end

endmodule

### rtl/lsfd_decode.sv
// Decode stage: segment patterns and indicator bits to registered result
module lsfd_decode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lsfd_pkg::frame_xfer_t head,
  output logic                  pop,
  output logic                  out_valid,
  output logic [23:0]           out_main_digits,
  output logic [3:0]            out_main_points,
  output logic                  out_main_negative,
  output logic [4:0]            out_main_prefix,
  output logic [7:0]            out_main_units,
  output logic [1:0]            out_coupling,
  output logic [9:0]            out_mode_flags,
  output logic [15:0]           out_aux_digits,
  output logic [2:0]            out_aux_points,
  output logic                  out_aux_negative,
  output logic [3:0]            out_aux_prefix,
  output logic [3:0]            out_aux_units
);
  import lsfd_pkg::*;

  frame_t      f;
  logic        valid_r;
  logic [23:0] main_digits_r, main_digits_nxt;
  logic [3:0]  main_points_r, main_points_nxt;
  logic        main_negative_r;
  logic [4:0]  main_prefix_r;
  logic [7:0]  main_units_r;
  logic [1:0]  coupling_r;
  logic [9:0]  mode_flags_r;
  logic [15:0] aux_digits_r, aux_digits_nxt;
  logic [2:0]  aux_points_r, aux_points_nxt;
  logic        aux_negative_r;
  logic [3:0]  aux_prefix_r;
  logic [3:0]  aux_units_r;

  assign f   = head.frame;
  assign pop = head.valid;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      main_digits_nxt[4*i +: 4] = seg_decode(f[2 + i][7:1]);
    end
    for (int i = 0; i < 4; i++) begin
      main_points_nxt[i]       = f[3 + i][0];
      aux_digits_nxt[4*i +: 4] = seg_decode(f[9 + i][7:1]);
    end
    for (int i = 0; i < 3; i++) begin
      aux_points_nxt[i] = f[10 + i][0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (head.valid) begin
      main_digits_r   <= main_digits_nxt;
      main_points_r   <= main_points_nxt;
      main_negative_r <= f[1][7];
      main_prefix_r   <= {f[14][5], f[14][6], f[14][2], f[14][3], f[13][6]};
      main_units_r    <= {f[14][0], f[14][1], f[14][4], f[14][7],
                          f[13][4], f[13][5], f[13][7], f[7][0]};
      coupling_r      <= {f[1][0], f[0][4]};
      mode_flags_r    <= {f[8][7], f[9][0], f[2][0], f[0][3], f[0][1],
                          f[0][2], f[0][5], f[0][6], f[0][7], f[0][0]};
      aux_digits_r    <= aux_digits_nxt;
      aux_points_r    <= aux_points_nxt;
      aux_negative_r  <= f[8][4];
      aux_prefix_r    <= {f[13][0], f[13][1], f[8][0], f[8][1]};
      aux_units_r     <= {f[8][3], f[8][2], f[13][3], f[13][2]};
    end
  end

  assign out_valid         = valid_r;
  assign out_main_digits   = main_digits_r;
  assign out_main_points   = main_points_r;
  assign out_main_negative = main_negative_r;
  assign out_main_prefix   = main_prefix_r;
  assign out_main_units    = main_units_r;
  assign out_coupling      = coupling_r;
  assign out_mode_flags    = mode_flags_r;
  assign out_aux_digits    = aux_digits_r;
  assign out_aux_points    = aux_points_r;
  assign out_aux_negative  = aux_negative_r;
  assign out_aux_prefix    = aux_prefix_r;
  assign out_aux_units     = aux_units_r;

endmodule

### rtl/lcd_segment_frame_decoder.sv
// Top level of the LCD segment frame decoder
// One frame byte is taken per cycle when start is high and busy is low; a byte
// with in_frame_start begins a new frame and drops any partial one. Bytes 0 to
// 14 are kept, 15 to 19 only counted, and bytes outside a frame are ignored.
// The twentieth byte hands the kept frame to a short queue; the decode stage
// drains one frame a cycle and shows the result with out_valid for exactly one
// cycle, once the frame has passed the queue and the decode register. The receiver
// cannot hold results off. busy rises only when the queue is full, which the
// one-frame-a-cycle drain keeps from happening, so bytes go in back to back.
module lcd_segment_frame_decoder #(
  parameter int unsigned QUEUE_DEPTH = lsfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_start,
  output logic        out_valid,
  output logic [23:0] out_main_digits,
  output logic [3:0]  out_main_points,
  output logic        out_main_negative,
  output logic [4:0]  out_main_prefix,
  output logic [7:0]  out_main_units,
  output logic [1:0]  out_coupling,
  output logic [9:0]  out_mode_flags,
  output logic [15:0] out_aux_digits,
  output logic [2:0]  out_aux_points,
  output logic        out_aux_negative,
  output logic [3:0]  out_aux_prefix,
  output logic [3:0]  out_aux_units
);
  import lsfd_pkg::*;
`include "lcd_segment_frame_decoder_macros.svh"

  logic          accept;
  logic          pop;
  logic          q_full;
  frame_xfer_t   push;
  frame_xfer_t   head;
  front_status_t status;

  assign accept = start && !busy;
  assign busy   = q_full;

  lsfd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .rx_byte     (in_rx_byte),
    .frame_start (in_frame_start),
    .push        (push),
    .status      (status)
  );

  lsfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (q_full)
  );

  lsfd_decode u_decode (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_main_digits   (out_main_digits),
    .out_main_points   (out_main_points),
    .out_main_negative (out_main_negative),
    .out_main_prefix   (out_main_prefix),
    .out_main_units    (out_main_units),
    .out_coupling      (out_coupling),
    .out_mode_flags    (out_mode_flags),
    .out_aux_digits    (out_aux_digits),
    .out_aux_points    (out_aux_points),
    .out_aux_negative  (out_aux_negative),
    .out_aux_prefix    (out_aux_prefix),
    .out_aux_units     (out_aux_units)
  );

  `LSFD_ASSERT_SAME(a_pos_range, 1'b1, status.pos <= POS_IDLE, "byte position out of range")
  `LSFD_ASSERT_LATER2(a_frame_result, status.done, out_valid, "completed frame gave no result")
  `LSFD_ASSERT_NEXT(a_result_spacing, out_valid, !out_valid, "results in adjacent cycles")
  `LSFD_ASSERT_SAME(a_done_needs_accept, status.done, accept && !in_frame_start,
                    "frame completed without a byte")

endmodule

### tb/sv/lcd_segment_frame_decoder_test.sv
// Self-checking testbench for the LCD segment frame decoder: directed and random frames
module lcd_segment_frame_decoder_test;
  import lsfd_pkg::*;

  localparam int TARGET_BYTES   = 950;
  localparam int MAX_GAP        = 13;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [23:0] main_digits;
    logic [3:0]  main_points;
    logic        main_negative;
    logic [4:0]  main_prefix;
    logic [7:0]  main_units;
    logic [1:0]  coupling;
    logic [9:0]  mode_flags;
    logic [15:0] aux_digits;
    logic [2:0]  aux_points;
    logic        aux_negative;
    logic [3:0]  aux_prefix;
    logic [3:0]  aux_units;
  } lcd_readout_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [7:0]  in_rx_byte;
  logic        in_frame_start;
  logic        out_valid;
  logic [23:0] out_main_digits;
  logic [3:0]  out_main_points;
  logic        out_main_negative;
  logic [4:0]  out_main_prefix;
  logic [7:0]  out_main_units;
  logic [1:0]  out_coupling;
  logic [9:0]  out_mode_flags;
  logic [15:0] out_aux_digits;
  logic [2:0]  out_aux_points;
  logic        out_aux_negative;
  logic [3:0]  out_aux_prefix;
  logic [3:0]  out_aux_units;

  logic [6:0]   seg_table [0:14];
  logic [7:0]   tx_frame [0:19];
  logic [7:0]   frame_img [0:14];
  logic [4:0]   frame_pos;
  lcd_readout_t pending_readouts [$];
  lcd_readout_t want;

  int mismatches;
  int readouts_checked;
  int frame_bytes;
  int ignored_bytes;
  int restarts;

  lcd_segment_frame_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_rx_byte       (in_rx_byte),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_main_digits  (out_main_digits),
    .out_main_points  (out_main_points),
    .out_main_negative(out_main_negative),
    .out_main_prefix  (out_main_prefix),
    .out_main_units   (out_main_units),
    .out_coupling     (out_coupling),
    .out_mode_flags   (out_mode_flags),
    .out_aux_digits   (out_aux_digits),
    .out_aux_points   (out_aux_points),
    .out_aux_negative (out_aux_negative),
    .out_aux_prefix   (out_aux_prefix),
    .out_aux_units    (out_aux_units)
  );

  always #5 clk = ~clk;

  function automatic logic [3:0] seg_to_code(input logic [6:0] pat);
    logic [3:0] code;
    code = CODE_UNKNOWN;
    for (int i = 0; i < 15; i++) begin
      if (seg_table[i] == pat) code = 4'(i);
    end
    return code;
  endfunction

  function automatic lcd_readout_t decode_frame();
    lcd_readout_t r;
    for (int i = 0; i < 6; i++) r.main_digits[4*i +: 4] = seg_to_code(frame_img[2+i][7:1]);
    for (int i = 0; i < 4; i++) r.main_points[i] = frame_img[3+i][0];
    for (int i = 0; i < 4; i++) r.aux_digits[4*i +: 4] = seg_to_code(frame_img[9+i][7:1]);
    for (int i = 0; i < 3; i++) r.aux_points[i] = frame_img[10+i][0];
    r.main_negative = frame_img[1][7];
    r.main_prefix   = {frame_img[14][5], frame_img[14][6], frame_img[14][2],
                       frame_img[14][3], frame_img[13][6]};
    r.main_units    = {frame_img[14][0], frame_img[14][1], frame_img[14][4],
                       frame_img[14][7], frame_img[13][4], frame_img[13][5],
                       frame_img[13][7], frame_img[7][0]};
    r.coupling      = {frame_img[1][0], frame_img[0][4]};
    r.mode_flags    = {frame_img[8][7], frame_img[9][0], frame_img[2][0],
                       frame_img[0][3], frame_img[0][1], frame_img[0][2],
                       frame_img[0][5], frame_img[0][6], frame_img[0][7],
                       frame_img[0][0]};
    r.aux_negative  = frame_img[8][4];
    r.aux_prefix    = {frame_img[13][0], frame_img[13][1], frame_img[8][0], frame_img[8][1]};
    r.aux_units     = {frame_img[8][3], frame_img[8][2], frame_img[13][3], frame_img[13][2]};
    return r;
  endfunction

  task automatic absorb_byte(input logic [7:0] b, input logic fs);
    if (fs) begin
      if (frame_pos != 0 && frame_pos < POS_IDLE) restarts++;
      frame_pos = '0;
    end else if (frame_pos >= POS_IDLE) begin
      ignored_bytes++;
      return;
    end
    if (frame_pos < POS_KEEP) frame_img[frame_pos[3:0]] = b;
    frame_pos = frame_pos + 5'd1;
    frame_bytes++;
    if (frame_pos == POS_IDLE) pending_readouts.push_back(decode_frame());
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fs, input bit idle_on);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    start          <= 1'b1;
    in_rx_byte     <= b;
    in_frame_start <= fs;
    @(posedge clk);
    while (busy) @(posedge clk);
    absorb_byte(b, fs);
  endtask

  task automatic send_frame(input int len, input int extra, input bit idle_on);
    for (int i = 0; i < len; i++) send_byte(tx_frame[i], i == 0, idle_on);
    for (int i = 0; i < extra; i++) send_byte(8'($urandom), 1'b0, idle_on);
  endtask

  function automatic logic [7:0] random_digit_byte();
    logic [6:0] pat;
    pat = ($urandom_range(0, 7) != 0) ? seg_table[4'($urandom_range(0, 14))] : 7'($urandom);
    return {pat, 1'($urandom)};
  endfunction

  task automatic fill_random_frame();
    for (int i = 0; i < 20; i++) begin
      if ((i >= 2 && i <= 7) || (i >= 9 && i <= 12)) tx_frame[i] = random_digit_byte();
      else tx_frame[i] = 8'($urandom);
    end
  endtask

  task automatic check_field(input string name, input logic [23:0] exp, input logic [23:0] act);
    if (exp !== act) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("ERROR: %s mismatch at %0t: expected 0x%0h, got 0x%0h", name, $time, exp, act);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_readouts.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected result at %0t with no frame outstanding", $time);
      end else begin
        want = pending_readouts.pop_front();
        check_field("main_digits", want.main_digits, out_main_digits);
        check_field("main_points", 24'(want.main_points), 24'(out_main_points));
        check_field("main_negative", 24'(want.main_negative), 24'(out_main_negative));
        check_field("main_prefix", 24'(want.main_prefix), 24'(out_main_prefix));
        check_field("main_units", 24'(want.main_units), 24'(out_main_units));
        check_field("coupling", 24'(want.coupling), 24'(out_coupling));
        check_field("mode_flags", 24'(want.mode_flags), 24'(out_mode_flags));
        check_field("aux_digits", 24'(want.aux_digits), 24'(out_aux_digits));
        check_field("aux_points", 24'(want.aux_points), 24'(out_aux_points));
        check_field("aux_negative", 24'(want.aux_negative), 24'(out_aux_negative));
        check_field("aux_prefix", 24'(want.aux_prefix), 24'(out_aux_prefix));
        check_field("aux_units", 24'(want.aux_units), 24'(out_aux_units));
        readouts_checked++;
      end
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || out_valid) stalled = 0;
      else stalled++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic test_idle_bytes();
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b1);
  endtask

  task automatic test_restart_mid_frame();
    fill_random_frame();
    send_frame(5, 0, 1'b1);
  endtask

  task automatic test_main_digits();
    for (int i = 0; i < 20; i++) tx_frame[i] = 8'h00;
    for (int i = 0; i < 6; i++) tx_frame[2+i] = {seg_table[i], 1'b0};
    for (int i = 0; i < 4; i++) tx_frame[9+i] = {seg_table[6+i], 1'b0};
    send_frame(20, 0, 1'b0);
  endtask

  task automatic test_special_codes();
    for (int i = 0; i < 20; i++) tx_frame[i] = 8'hFF;
    for (int i = 0; i < 5; i++) tx_frame[2+i] = {seg_table[10+i], 1'b1};
    tx_frame[7]  = {7'b0000001, 1'b1};
    tx_frame[9]  = {7'b1000000, 1'b1};
    tx_frame[10] = {SEG_BLANK, 1'b1};
    tx_frame[11] = {SEG_L, 1'b1};
    tx_frame[12] = {SEG_D, 1'b1};
    send_frame(20, 0, 1'b1);
  endtask

  task automatic test_trailing_bytes();
    fill_random_frame();
    send_frame(20, 3, 1'b1);
  endtask

  task automatic test_random_frames();
    int kind;
    int len;
    int extra;
    while (frame_bytes < TARGET_BYTES) begin
      kind  = $urandom_range(0, 19);
      len   = 20;
      extra = 0;
      if (kind < 2) len = $urandom_range(1, 19);
      else if (kind < 4) extra = $urandom_range(1, 4);
      fill_random_frame();
      send_frame(len, extra, $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    seg_table = '{SEG_0, SEG_1, SEG_2, SEG_3, SEG_4, SEG_5, SEG_6, SEG_7,
                  SEG_8, SEG_9, SEG_D, SEG_I, SEG_O, SEG_L, SEG_BLANK};
    for (int i = 0; i < 15; i++) frame_img[i] = 8'h00;
    frame_pos        = POS_IDLE;
    mismatches       = 0;
    readouts_checked = 0;
    frame_bytes      = 0;
    ignored_bytes    = 0;
    restarts         = 0;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_rx_byte       = 8'h00;
    in_frame_start   = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_bytes();
    test_restart_mid_frame();
    test_main_digits();
    test_special_codes();
    test_trailing_bytes();
    test_random_frames();

    @(negedge clk);
    start <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d frame bytes, %0d ignored bytes and %0d mid-frame restarts;",
             frame_bytes, ignored_bytes, restarts);
    $display("%0d decoded frames were checked, %0d mismatches", readouts_checked, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
